// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: beat types, codes, defaults.
// No dependencies; used by every deque module except cdq_ram.
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CAP_W          = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input beat
    logic exec;      // evaluate command, update indices, access memory
    logic load_out;  // move result into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cdq_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cdq_datapath.sv -----
// Deque datapath: capacity register, indices, memory port, output register.
// Depends on cdq_pkg, cdq_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cdq_datapath #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0]  cfg_data_i,
  input  wire cdq_pkg::in_item_t          in_data_i,
  input  wire cdq_pkg::ctl_cmd_t          cmd_i,
  output cdq_pkg::dp_stat_t               stat_o,
  output cdq_pkg::out_item_t              out_data_o
);

  import cdq_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]            cmd_q;
  logic [31:0]           value_q;
  logic [IW-1:0]         front_q, front_d;
  logic [IW-1:0]         rear_q, rear_d;
  logic                  empty_q, empty_d;
  logic [CAP_W-1:0]      cap_q;
  logic [1:0]            stat_q, stat_d;
  logic                  popok_q, popok_d;
  out_item_t             out_q;

  logic [CAP_W-1:0]      cap_eff, capm1;
  logic [IW-1:0]         capm1_ix;
  logic                  front_top, rear_top, full, is_push;
  logic [IW-1:0]         front_up, front_dn, rear_up, rear_dn;

  logic                  ram_en, ram_we;
  logic [IW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]           wr_ext, rd_ext;

  // capacity clamp: zero acts as one, anything above DEPTH acts as DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign capm1     = cap_eff - CAP_W'(1);
  assign capm1_ix  = IW'(capm1);
  assign front_top = 32'(front_q) >= 32'(capm1);
  assign rear_top  = 32'(rear_q) >= 32'(capm1);
  assign front_up  = front_top ? '0 : front_q + IW'(1);
  assign rear_up   = rear_top ? '0 : rear_q + IW'(1);
  assign front_dn  = (front_q == '0) ? capm1_ix : front_q - IW'(1);
  assign rear_dn   = (rear_q == '0) ? capm1_ix : rear_q - IW'(1);
  assign is_push   = !cmd_q[1];
  assign full      = !empty_q &&
                     ((front_q == '0 && rear_top) ||
                      (32'(front_q) == 32'(rear_q) + 32'd1));

  assign wr_ext    = {32'd0, value_q};
  assign ram_wdata = wr_ext[DATA_WIDTH-1:0];
  assign rd_ext    = 64'(ram_rdata);

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    stat_d   = stat_q;
    popok_d  = popok_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    if (cmd_i.exec) begin
      stat_d  = ST_DONE;
      popok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          stat_d = ST_FULL;
        end else if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
          ram_en  = 1'b1;
          ram_we  = 1'b1;
        end else if (cmd_q == CMD_PUSH_FRONT) begin
          front_d  = front_dn;
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = front_dn;
        end else begin
          rear_d   = rear_up;
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = rear_up;
        end
      end else begin
        if (empty_q) begin
          stat_d = ST_EMPTY;
        end else begin
          popok_d = 1'b1;
          ram_en  = 1'b1;
          if (front_q == rear_q) begin
            // last entry leaves
            ram_addr = front_q;
            front_d  = '0;
            rear_d   = '0;
            empty_d  = 1'b1;
          end else if (cmd_q == CMD_POP_FRONT) begin
            ram_addr = front_q;
            front_d  = front_up;
          end else begin
            ram_addr = rear_q;
            rear_d   = rear_dn;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      cap_q   <= CAP_RESET;
      stat_q  <= ST_DONE;
      popok_q <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      stat_q  <= stat_d;
      popok_q <= popok_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= in_data_i.cmd;
      value_q <= in_data_i.value;
    end
    if (cmd_i.load_out) begin
      out_q.popped <= popok_q ? $signed(rd_ext[31:0]) : '0;
      out_q.status <= stat_q;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign stat_o.empty = empty_q;
  assign out_data_o   = out_q;

  `ASSERT_IMP(a_empty_idx_zero, clk_i, rst_ni, empty_q, (front_q == '0 && rear_q == '0), "empty deque with nonzero index")
  `ASSERT_IMP(a_full_not_empty, clk_i, rst_ni, (cmd_i.exec && is_push && full), !empty_q, "full reported on empty deque")
  `ASSERT_NXT(a_pop_sets_flag, clk_i, rst_ni, (cmd_i.exec && !is_push && !empty_q), (popok_q && stat_q == ST_DONE), "pop result flags lost")

endmodule

`default_nettype wire

// ----- rtl/cdq_ctrl.sv -----
// Deque controller: sequences accept, execute and respond; owns output valid.
// Depends on cdq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cdq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire cdq_pkg::dp_stat_t  stat_i,
  output cdq_pkg::ctl_cmd_t       cmd_o
);

  import cdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, slot_free, load;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load      = (state_q == S_RESP) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.latch    = accept;
  assign cmd_o.exec     = (state_q == S_EXEC);
  assign cmd_o.load_out = load;

  `ASSERT_NXT(a_accept_exec, clk_i, rst_ni, accept, (state_q == S_EXEC), "accepted beat not executed")
  `ASSERT_NXT(a_load_valid, clk_i, rst_ni, load, out_valid_q, "result loaded without valid")
  `ASSERT_IMP(a_idle_after_reset, clk_i, rst_ni, (state_q == S_IDLE && !out_valid_q && $past(!rst_ni)), stat_i.empty, "deque not empty out of reset")

endmodule

`default_nettype wire

// ----- rtl/circular_deque.sv -----
// Circular deque top level: controller, datapath and storage RAM.
// Depends on cdq_pkg, cdq_ctrl, cdq_datapath (which holds cdq_ram).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
//   beat: push front, push back, pop front or pop back, plus the value to push.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   beat per command: the popped value (zero unless a pop succeeded) and a
//   status of done, full (push refused) or empty (pop refused).
//   cfg_we_i / cfg_data_i write the capacity in use (1..DEPTH, reset 128);
//   write it only while no command is in flight.
// Timing:
//   A command accepted at a clock edge is executed in the following cycle (index
//   update plus one RAM access, whose read data is registered); in the respond
//   step, once the output slot is free, the result moves into the output register
//   and out_valid_o rises. The controller steps through accept, execute and
//   respond and takes no new command until it is back in idle.
//   A stalled result stays in the output register; the next command may be
//   accepted and executed meanwhile, and waits in its respond step for the slot.
// Reset: indices cleared, deque empty, capacity 128; RAM contents undefined.
`default_nettype none

module circular_deque #(
  parameter int unsigned DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire cdq_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output cdq_pkg::out_item_t             out_data_o
);

  import cdq_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (ctl_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/circular_deque_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque: directed and random deque commands,
// with results checked beat by beat against a built-in deque predictor.
// Depends on cdq_pkg and the circular_deque RTL; needs no other files.
module circular_deque_test;
  import cdq_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1850;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned MEM_DEPTH      = DEPTH_DEF;

  typedef enum int unsigned {
    STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY
  } stall_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CAP_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  circular_deque u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state of the deque
  logic signed [31:0] dq_mem [MEM_DEPTH];
  int unsigned        dq_front = 0;
  int unsigned        dq_rear  = 0;
  bit                 dq_empty = 1'b1;
  logic [CAP_W-1:0]   dq_cap   = CAP_RESET;

  in_item_t    cmd_q[$];
  out_item_t   exp_q[$];
  int unsigned n_queued = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int unsigned n_full = 0, n_empty = 0, n_popped = 0, n_cfg = 0;
  int unsigned quiet = 0;
  bit          took_beat = 1'b0;
  int unsigned hold_req = 0;

  function automatic int unsigned eff_cap(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > MEM_DEPTH) return MEM_DEPTH;
    return c;
  endfunction

  function automatic out_item_t deque_step(in_item_t beat);
    out_item_t   res;
    int unsigned cap;
    bit          full;
    res.popped = '0;
    res.status = ST_DONE;
    cap = eff_cap(dq_cap);
    if (beat.cmd == CMD_PUSH_FRONT || beat.cmd == CMD_PUSH_BACK) begin
      full = !dq_empty &&
             ((dq_front == 0 && dq_rear >= cap - 1) || dq_front == dq_rear + 1);
      if (full) begin
        res.status = ST_FULL;
        n_full++;
      end else if (dq_empty) begin
        // first entry always lands in slot 0
        dq_front = 0;
        dq_rear = 0;
        dq_empty = 1'b0;
        dq_mem[0] = beat.value;
      end else if (beat.cmd == CMD_PUSH_FRONT) begin
        dq_front = (dq_front == 0) ? cap - 1 : dq_front - 1;
        dq_mem[dq_front] = beat.value;
      end else begin
        dq_rear = (dq_rear >= cap - 1) ? 0 : dq_rear + 1;
        dq_mem[dq_rear] = beat.value;
      end
    end else begin
      if (dq_empty) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        n_popped++;
        if (dq_front == dq_rear) begin
          res.popped = dq_mem[dq_front];
          dq_front = 0;
          dq_rear = 0;
          dq_empty = 1'b1;
        end else if (beat.cmd == CMD_POP_FRONT) begin
          res.popped = dq_mem[dq_front];
          dq_front = (dq_front >= cap - 1) ? 0 : dq_front + 1;
        end else begin
          res.popped = dq_mem[dq_rear];
          dq_rear = (dq_rear == 0) ? cap - 1 : dq_rear - 1;
        end
      end
    end
    return res;
  endfunction

  task automatic note_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  // Check output beats first, then predict the input beat of the same edge.
  always @(posedge clk_i) begin
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    took_beat = 1'b0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      n_checked++;
      if (exp_q.size() == 0) begin
        note_error($sformatf("result beat with nothing pending: popped %0d status %0d",
                             out_data_o.popped, out_data_o.status));
      end else begin
        want = exp_q.pop_front();
        if (out_data_o.popped !== want.popped || out_data_o.status !== want.status)
          note_error($sformatf("result %0d: expected popped %0d status %0d, got popped %0d status %0d",
                               n_checked, want.popped, want.status,
                               out_data_o.popped, out_data_o.status));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      moved = 1'b1;
      took_beat = 1'b1;
      n_accepted++;
      exp_q.push_back(deque_step(in_data_i));
    end
    if (moved) quiet = 0;
    else quiet++;
  end

  always @(negedge clk_i) begin
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet, exp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_beat)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= cmd_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes per segment; long hold-off on request
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned stall_phase = 0;
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
        stall_phase = 0;
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_COIN:     out_stall_i <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_stall_i <= (stall_phase % 3 == 0);
        default:        out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e any_push();
    return ($urandom_range(0, 1) == 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
  endfunction

  function automatic cmd_e any_pop();
    return ($urandom_range(0, 1) == 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  task automatic send(cmd_e c, logic [31:0] v);
    in_item_t beat;
    beat.cmd = c;
    beat.value = v;
    cmd_q.push_back(beat);
    n_queued++;
  endtask

  // Every queued command has produced its result beat.
  task automatic wait_idle();
    while (n_checked != n_queued) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= c;
    dq_cap = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  task automatic drain_deque();
    wait_idle();
    while (!dq_empty) begin
      send(any_pop(), rand_value());
      wait_idle();
    end
  endtask

  // Alternating push runs and pop runs so that full and empty are hit often.
  task automatic run_phase(int unsigned n);
    int unsigned cap, done, run, k;
    bit          pushing;
    cap = eff_cap(dq_cap);
    done = 0;
    pushing = 1'b1;
    while (done < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send(cmd_e'($urandom_range(0, 3)), rand_value());
        done++;
      end else begin
        run = $urandom_range(1, cap + 2);
        for (k = 0; k < run; k++)
          send(pushing ? any_push() : any_pop(), rand_value());
        done += run;
        if ($urandom_range(0, 2) != 0) pushing = !pushing;
      end
    end
  endtask

  initial begin
    int unsigned      k, eff, len;
    logic [CAP_W-1:0] cap_pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops, extreme values, last pop empties the deque
    send(CMD_POP_FRONT, 32'h1234_5678);
    send(CMD_POP_BACK, 32'hffff_ffff);
    send(CMD_PUSH_BACK, 32'h7fff_ffff);
    send(CMD_PUSH_FRONT, 32'h8000_0000);
    send(CMD_POP_BACK, 32'h0);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_PUSH_FRONT, 32'h0000_0000);
    send(CMD_PUSH_BACK, 32'hffff_ffff);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_POP_BACK, 32'h0);
    send(CMD_POP_BACK, 32'h0);
    // single entry: one push fills it
    set_capacity(8'd1);
    send(CMD_PUSH_FRONT, 32'h5a5a_5a5a);
    send(CMD_PUSH_BACK, 32'ha5a5_a5a5);
    send(CMD_POP_BACK, 32'h0);
    // front wraps down, full by front == rear + 1, front wraps up on pop
    set_capacity(8'd3);
    send(CMD_PUSH_BACK, 32'h0000_0011);
    send(CMD_PUSH_FRONT, 32'h0000_0022);
    send(CMD_PUSH_FRONT, 32'h0000_0033);
    send(CMD_PUSH_BACK, 32'h0000_0044);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_POP_FRONT, 32'h0);
    send(CMD_POP_BACK, 32'h0);
    // capacity zero acts as one, oversize acts as the full depth
    set_capacity(8'd0);
    send(CMD_PUSH_BACK, 32'hdead_beef);
    send(CMD_PUSH_FRONT, 32'h0bad_f00d);
    send(CMD_POP_FRONT, 32'h0);
    set_capacity(8'hff);
    send(CMD_PUSH_FRONT, 32'hcafe_0001);
    send(CMD_POP_BACK, 32'h0);

    // Fill the whole store while the receiver holds off, then empty it
    drain_deque();
    set_capacity(8'd128);
    hold_req = HOLD_CYCLES;
    for (k = 0; k < MEM_DEPTH + 2; k++) send(any_push(), rand_value());
    for (k = 0; k < MEM_DEPTH + 2; k++) send(any_pop(), rand_value());

    // Shrink the capacity while holding entries; every slot is written by now
    drain_deque();
    for (k = 0; k < 10; k++) send(any_push(), rand_value());
    set_capacity(8'd5);
    for (k = 0; k < 20; k++) send(cmd_e'($urandom_range(0, 3)), rand_value());
    // restore full range so the indices can meet again while draining
    set_capacity(8'd128);
    drain_deque();

    while (n_queued < ITEM_TARGET) begin
      drain_deque();
      case ($urandom_range(0, 19))
        0:       cap_pick = 8'd0;
        1:       cap_pick = $urandom_range(129, 255);
        2:       cap_pick = 8'd128;
        3:       cap_pick = 8'd127;
        4, 5, 6: cap_pick = $urandom_range(9, 40);
        default: cap_pick = $urandom_range(1, 8);
      endcase
      set_capacity(cap_pick);
      eff = eff_cap(dq_cap);
      len = (eff >= 64) ? $urandom_range(200, 320) : $urandom_range(40, 120);
      // keep the total close to the target
      if (n_queued + len > ITEM_TARGET)
        len = (n_queued < ITEM_TARGET) ? ITEM_TARGET - n_queued : 0;
      run_phase(len);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (exp_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", exp_q.size()));
    $display("Run: %0d commands accepted, %0d results checked, %0d capacity writes",
             n_accepted, n_checked, n_cfg);
    $display("Run: %0d pops returned data, %0d pushes refused full, %0d pops refused empty",
             n_popped, n_full, n_empty);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_datapath.sv
rtl/cdq_ctrl.sv
rtl/circular_deque.sv
tb/circular_deque_test.sv
